FILE: src/spsrv_pkg.sv
// Shared types and constants for the steering position servo.
package spsrv_pkg;

  localparam int NUM_W      = 20;  // divider dividend / quotient width
  localparam int DEN_W      = 12;  // divider divisor width
  localparam int ADC_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PCT_W      = 7;
  localparam int DUTY_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WDOG_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_PCT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH  = 3'd6;

  // request kinds
  localparam logic [1:0] REQ_SAMPLE    = 2'd0;
  localparam logic [1:0] REQ_COMMAND   = 2'd1;
  localparam logic [1:0] REQ_EMERGENCY = 2'd2;
  localparam logic [1:0] REQ_TICK      = 2'd3;

  // drive directions
  localparam logic [1:0] DIR_STOP    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  localparam logic [DEN_W-1:0]  PCT_SCALE  = 12'd100;
  localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;
  localparam logic [15:0]       SILENCE_MAX = 16'hFFFF;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/spsrv_div.sv
// Restoring serial divider, one quotient bit per cycle.
module spsrv_div (
  input  logic                clk,
  input  logic                rst_n,
  input  spsrv_pkg::div_req_t req,
  output spsrv_pkg::div_rsp_t rsp
);
  import spsrv_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

FILE: src/steering_position_servo.sv
// Steering position servo: filter, deadband and proportional drive, commands, watchdog.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  req_type, adc_sample, payload_byte, has_payload
//  out_     output     out_valid/out_stall  drive_*, feedback_valid, position_pct, span_fault
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction at a time; in_stall is high from acceptance until the result
// is handed to the output register. All divisions go through one serial divider.
// A control sample takes up to three divisions, a command up to two, an emergency
// frame up to one, and a tick or a blocked sample none.
// Reset is synchronous; cfg_ready is always high. A result waiting on out_stall
// holds the sequencer in its output state, the window memory needs no clearing.
module steering_position_servo #(
  parameter int WINDOW_TAPS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [spsrv_pkg::ADC_W-1:0]        in_adc_sample,
  input  logic [7:0]                         in_payload_byte,
  input  logic                               in_has_payload,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_drive_valid,
  output logic [1:0]                         out_drive_dir,
  output logic [spsrv_pkg::DUTY_W-1:0]       out_drive_duty,
  output logic                               out_feedback_valid,
  output logic [spsrv_pkg::PCT_W-1:0]        out_position_pct,
  output logic                               out_span_fault,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spsrv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spsrv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spsrv_pkg::*;

  localparam int SLOT_W = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
  localparam int SUM_W  = $clog2(WINDOW_TAPS * 4095 + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_SUM  = 9'b000000100,
    S_FDIV = 9'b000001000,
    S_TOL  = 9'b000010000,
    S_DUTY = 9'b000100000,
    S_TGT  = 9'b001000000,
    S_FB   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ADC_W-1:0]  cal_left_r,   cal_left_nxt;
  logic [ADC_W-1:0]  cal_right_r,  cal_right_nxt;
  logic [15:0]       wdog_limit_r, wdog_limit_nxt;
  logic [PCT_W-1:0]  tol_pct_r,    tol_pct_nxt;
  logic [ADC_W-1:0]  tol_floor_r,  tol_floor_nxt;
  logic [DUTY_W-1:0] duty_low_r,   duty_low_nxt;
  logic [DUTY_W-1:0] duty_high_r,  duty_high_nxt;

  // servo state
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              full_r, full_nxt;
  logic [ADC_W-1:0]  filtered_r, filtered_nxt;
  logic [ADC_W-1:0]  target_r, target_nxt;
  logic              tvalid_r, tvalid_nxt;
  logic              emerg_r, emerg_nxt;
  logic              offline_r, offline_nxt;
  logic [15:0]       silence_r, silence_nxt;

  // per-transaction working registers
  logic [ADC_W-1:0]  adc_r, adc_nxt;
  logic [ADC_W-1:0]  mag_r, mag_nxt;
  logic              err_neg_r, err_neg_nxt;

  // pending result
  logic              res_dv_r, res_dv_nxt;
  logic [1:0]        res_dir_r, res_dir_nxt;
  logic [DUTY_W-1:0] res_duty_r, res_duty_nxt;
  logic              res_fv_r, res_fv_nxt;
  logic [PCT_W-1:0]  res_pos_r, res_pos_nxt;
  logic              res_fault_r, res_fault_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic              o_dv_r, o_dv_nxt;
  logic [1:0]        o_dir_r, o_dir_nxt;
  logic [DUTY_W-1:0] o_duty_r, o_duty_nxt;
  logic              o_fv_r, o_fv_nxt;
  logic [PCT_W-1:0]  o_pos_r, o_pos_nxt;
  logic              o_fault_r, o_fault_nxt;

  // moving-average window, registered read
  logic [ADC_W-1:0]  win_mem [WINDOW_TAPS];
  logic [ADC_W-1:0]  win_rd_r;
  logic              win_we;

  div_req_t div_req;
  div_rsp_t div_rsp;

  spsrv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // combinational helpers
  logic              in_acc;
  logic [ADC_W-1:0]  span;
  logic              right_ge;
  logic [ADC_W-1:0]  cal_lo, cal_hi, fb_clamp, fb_dist;
  logic [SUM_W-1:0]  sum_upd;
  logic [ADC_W-1:0]  q12;
  logic [NUM_W-1:0]  tol_eff;
  logic              duty_down;
  logic [DUTY_W-1:0] duty_diff;
  logic [NUM_W:0]    duty_up_sum;
  logic [PCT_W-1:0]  cmd_pct;
  logic [15:0]       silence_inc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign right_ge  = cal_right_r >= cal_left_r;
  assign span      = right_ge ? (cal_right_r - cal_left_r) : (cal_left_r - cal_right_r);
  assign cal_lo    = right_ge ? cal_left_r : cal_right_r;
  assign cal_hi    = right_ge ? cal_right_r : cal_left_r;
  assign fb_clamp  = (filtered_r < cal_lo) ? cal_lo :
                     ((filtered_r > cal_hi) ? cal_hi : filtered_r);
  assign fb_dist   = right_ge ? (fb_clamp - cal_left_r) : (cal_left_r - fb_clamp);

  assign sum_upd   = sum_r - (full_r ? SUM_W'(win_rd_r) : '0) + SUM_W'(adc_r);
  assign q12       = div_rsp.quot[ADC_W-1:0];
  assign tol_eff   = (div_rsp.quot < NUM_W'(tol_floor_r)) ? NUM_W'(tol_floor_r) : div_rsp.quot;

  assign duty_down   = duty_high_r < duty_low_r;
  assign duty_diff   = duty_down ? (duty_low_r - duty_high_r) : (duty_high_r - duty_low_r);
  assign duty_up_sum = {1'b0, div_rsp.quot} + (NUM_W + 1)'(duty_low_r);

  assign cmd_pct     = (in_payload_byte > 8'(PCT_MAX)) ? PCT_MAX : in_payload_byte[PCT_W-1:0];
  assign silence_inc = (silence_r == SILENCE_MAX) ? silence_r : silence_r + 16'd1;

  always_comb begin
    state_nxt      = state_r;
    cal_left_nxt   = cal_left_r;
    cal_right_nxt  = cal_right_r;
    wdog_limit_nxt = wdog_limit_r;
    tol_pct_nxt    = tol_pct_r;
    tol_floor_nxt  = tol_floor_r;
    duty_low_nxt   = duty_low_r;
    duty_high_nxt  = duty_high_r;
    sum_nxt        = sum_r;
    slot_nxt       = slot_r;
    full_nxt       = full_r;
    filtered_nxt   = filtered_r;
    target_nxt     = target_r;
    tvalid_nxt     = tvalid_r;
    emerg_nxt      = emerg_r;
    offline_nxt    = offline_r;
    silence_nxt    = silence_r;
    adc_nxt        = adc_r;
    mag_nxt        = mag_r;
    err_neg_nxt    = err_neg_r;
    res_dv_nxt     = res_dv_r;
    res_dir_nxt    = res_dir_r;
    res_duty_nxt   = res_duty_r;
    res_fv_nxt     = res_fv_r;
    res_pos_nxt    = res_pos_r;
    res_fault_nxt  = res_fault_r;
    ov_nxt         = ov_r && out_stall;
    o_dv_nxt       = o_dv_r;
    o_dir_nxt      = o_dir_r;
    o_duty_nxt     = o_duty_r;
    o_fv_nxt       = o_fv_r;
    o_pos_nxt      = o_pos_r;
    o_fault_nxt    = o_fault_r;
    win_we         = 1'b0;
    div_req.start  = 1'b0;
    div_req.num    = '0;
    div_req.den    = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_CAL_LEFT:   cal_left_nxt   = cfg_data[ADC_W-1:0];
        CFG_CAL_RIGHT:  cal_right_nxt  = cfg_data[ADC_W-1:0];
        CFG_WDOG_LIMIT: wdog_limit_nxt = cfg_data;
        CFG_TOL_PCT:    tol_pct_nxt    = cfg_data[PCT_W-1:0];
        CFG_TOL_FLOOR:  tol_floor_nxt  = cfg_data[ADC_W-1:0];
        CFG_DUTY_LOW:   duty_low_nxt   = cfg_data[DUTY_W-1:0];
        CFG_DUTY_HIGH:  duty_high_nxt  = cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_dv_nxt    = 1'b0;
          res_dir_nxt   = DIR_STOP;
          res_duty_nxt  = '0;
          res_fv_nxt    = 1'b0;
          res_pos_nxt   = '0;
          res_fault_nxt = 1'b0;
          adc_nxt       = in_adc_sample;
          case (in_req_type)
            REQ_SAMPLE: begin
              res_dv_nxt = 1'b1;
              // blocked step: plain stop, sample not filtered
              state_nxt  = (offline_r || emerg_r) ? S_OUT : S_RD;
            end
            REQ_COMMAND: begin
              silence_nxt = '0;
              offline_nxt = 1'b0;
              if (!emerg_r && in_has_payload) begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(cmd_pct) * NUM_W'(span);
                div_req.den   = PCT_SCALE;
                state_nxt     = S_TGT;
              end
            end
            REQ_EMERGENCY: begin
              silence_nxt = '0;
              offline_nxt = 1'b0;
              if (in_has_payload) begin
                emerg_nxt  = (in_payload_byte == 8'd1);
                res_dv_nxt = (in_payload_byte == 8'd1);
                res_fv_nxt = 1'b1;
                if (span == '0) begin
                  res_fault_nxt = 1'b1;
                  state_nxt     = S_OUT;
                end else begin
                  div_req.start = 1'b1;
                  div_req.num   = NUM_W'(fb_dist) * NUM_W'(PCT_SCALE);
                  div_req.den   = span;
                  state_nxt     = S_FB;
                end
              end
            end
            default: begin  // millisecond tick
              silence_nxt = silence_inc;
              if (!offline_r && (silence_inc > wdog_limit_r)) begin
                offline_nxt = 1'b1;
                res_dv_nxt  = 1'b1;
                state_nxt   = S_OUT;
              end
            end
          endcase
        end
      end
      S_RD: state_nxt = S_SUM;  // window entry read in flight
      S_SUM: begin
        win_we  = 1'b1;
        sum_nxt = sum_upd;
        if (slot_r == SLOT_W'(WINDOW_TAPS - 1)) begin
          slot_nxt = '0;
          full_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
        // divisor is the sample count until the window fills, then the tap count
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(sum_upd);
        div_req.den   = full_r ? DEN_W'(WINDOW_TAPS) : (DEN_W'(slot_r) + 1'b1);
        state_nxt     = S_FDIV;
      end
      S_FDIV: begin
        if (div_rsp.done) begin
          filtered_nxt = q12;
          err_neg_nxt  = target_r < q12;
          mag_nxt      = (target_r < q12) ? (q12 - target_r) : (target_r - q12);
          if (!tvalid_r) begin
            state_nxt = S_OUT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(span) * NUM_W'(tol_pct_r);
            div_req.den   = PCT_SCALE;
            state_nxt     = S_TOL;
          end
        end
      end
      S_TOL: begin
        if (div_rsp.done) begin
          if (NUM_W'(mag_r) <= tol_eff) begin
            state_nxt = S_OUT;
          end else begin
            res_dir_nxt = err_neg_r ? DIR_REVERSE : DIR_FORWARD;
            if (span == '0) begin
              res_duty_nxt = duty_high_r;
              state_nxt    = S_OUT;
            end else begin
              div_req.start = 1'b1;
              div_req.num   = NUM_W'(mag_r) * NUM_W'(duty_diff);
              div_req.den   = span;
              state_nxt     = S_DUTY;
            end
          end
        end
      end
      S_DUTY: begin
        if (div_rsp.done) begin
          if (duty_down) begin
            res_duty_nxt = (div_rsp.quot > NUM_W'(duty_low_r)) ? '0 :
                           (duty_low_r - div_rsp.quot[DUTY_W-1:0]);
          end else begin
            res_duty_nxt = (duty_up_sum > (NUM_W + 1)'(255)) ? 8'hFF :
                           duty_up_sum[DUTY_W-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_TGT: begin
        if (div_rsp.done) begin
          target_nxt = right_ge ? (cal_left_r + q12) : (cal_left_r - q12);
          tvalid_nxt = 1'b1;
          res_fv_nxt = 1'b1;
          if (span == '0) begin
            res_fault_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(fb_dist) * NUM_W'(PCT_SCALE);
            div_req.den   = span;
            state_nxt     = S_FB;
          end
        end
      end
      S_FB: begin
        if (div_rsp.done) begin
          res_pos_nxt = div_rsp.quot[PCT_W-1:0];
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt      = 1'b1;
          o_dv_nxt    = res_dv_r;
          o_dir_nxt   = res_dir_r;
          o_duty_nxt  = res_duty_r;
          o_fv_nxt    = res_fv_r;
          o_pos_nxt   = res_pos_r;
          o_fault_nxt = res_fault_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cal_left_r   <= 12'd1242;
      cal_right_r  <= 12'd2865;
      wdog_limit_r <= 16'd500;
      tol_pct_r    <= 7'd4;
      tol_floor_r  <= 12'd25;
      duty_low_r   <= 8'd135;
      duty_high_r  <= 8'd195;
      sum_r        <= '0;
      slot_r       <= '0;
      full_r       <= 1'b0;
      filtered_r   <= '0;
      target_r     <= '0;
      tvalid_r     <= 1'b0;
      emerg_r      <= 1'b0;
      offline_r    <= 1'b1;
      silence_r    <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cal_left_r   <= cal_left_nxt;
      cal_right_r  <= cal_right_nxt;
      wdog_limit_r <= wdog_limit_nxt;
      tol_pct_r    <= tol_pct_nxt;
      tol_floor_r  <= tol_floor_nxt;
      duty_low_r   <= duty_low_nxt;
      duty_high_r  <= duty_high_nxt;
      sum_r        <= sum_nxt;
      slot_r       <= slot_nxt;
      full_r       <= full_nxt;
      filtered_r   <= filtered_nxt;
      target_r     <= target_nxt;
      tvalid_r     <= tvalid_nxt;
      emerg_r      <= emerg_nxt;
      offline_r    <= offline_nxt;
      silence_r    <= silence_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adc_r       <= adc_nxt;
    mag_r       <= mag_nxt;
    err_neg_r   <= err_neg_nxt;
    res_dv_r    <= res_dv_nxt;
    res_dir_r   <= res_dir_nxt;
    res_duty_r  <= res_duty_nxt;
    res_fv_r    <= res_fv_nxt;
    res_pos_r   <= res_pos_nxt;
    res_fault_r <= res_fault_nxt;
    o_dv_r      <= o_dv_nxt;
    o_dir_r     <= o_dir_nxt;
    o_duty_r    <= o_duty_nxt;
    o_fv_r      <= o_fv_nxt;
    o_pos_r     <= o_pos_nxt;
    o_fault_r   <= o_fault_nxt;
  end

  // before the window fills, the slot being written was never written, and the
  // subtracted value is forced to zero above, so no clearing is needed
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[slot_r] <= adc_r;
    end
    win_rd_r <= win_mem[slot_r];
  end

  assign out_valid          = ov_r;
  assign out_drive_valid    = o_dv_r;
  assign out_drive_dir      = o_dir_r;
  assign out_drive_duty     = o_duty_r;
  assign out_feedback_valid = o_fv_r;
  assign out_position_pct   = o_pos_r;
  assign out_span_fault     = o_fault_r;

endmodule

FILE: src/spsrv_chk.sv
// Port-level checker for the steering position servo, with its bind.
module spsrv_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_drive_valid,
  input logic [1:0] out_drive_dir,
  input logic [7:0] out_drive_duty,
  input logic       out_feedback_valid,
  input logic [6:0] out_position_pct,
  input logic       out_span_fault
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_dir) &&
      $stable(out_drive_duty) && $stable(out_position_pct))
    else $error("stalled result changed");

  a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_valid |-> out_drive_dir == 2'd0 && out_drive_duty == 8'd0)
    else $error("drive fields set without drive update");

  a_no_fb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_feedback_valid |-> out_position_pct == 7'd0 && !out_span_fault)
    else $error("feedback fields set without feedback");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position_pct <= 7'd100 && out_drive_dir != 2'd3)
    else $error("result field out of range");

  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_dir == 2'd0 |-> out_drive_duty == 8'd0)
    else $error("stop with nonzero duty");

endmodule

bind steering_position_servo spsrv_chk u_spsrv_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_drive_valid    (out_drive_valid),
  .out_drive_dir      (out_drive_dir),
  .out_drive_duty     (out_drive_duty),
  .out_feedback_valid (out_feedback_valid),
  .out_position_pct   (out_position_pct),
  .out_span_fault     (out_span_fault)
);

FILE: tb/steering_position_servo_tb.sv
// Self-checking testbench for the steering position servo: directed and random traffic.
`timescale 1ns / 100ps

module steering_position_servo_tb;
  import spsrv_pkg::*;

  // One input transaction as driven on the in_ channel.
  typedef struct {
    logic [1:0]       kind;
    logic [ADC_W-1:0] adc;
    logic [7:0]       pay;
    logic             has;
  } servo_req_t;

  // One result transaction as seen on the out_ channel.
  typedef struct {
    logic             drv_valid;
    logic [1:0]       dir;
    logic [DUTY_W-1:0] duty;
    logic             fb_valid;
    logic [PCT_W-1:0] pct;
    logic             span_fault;
  } servo_rsp_t;

  localparam int TAPS        = 12;
  localparam int SETTLE_CYC  = 200;   // covers the slowest transaction plus margin
  localparam int STUCK_LIMIT = 20000; // cycles without any handshake
  localparam int QUIET_FROM  = 4000;  // stretch with no idling on either side
  localparam int QUIET_TO    = 8000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_TICK;
  logic [ADC_W-1:0] in_adc_sample = '0;
  logic [7:0] in_payload_byte = '0;
  logic in_has_payload = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_drive_valid;
  logic [1:0] out_drive_dir;
  logic [DUTY_W-1:0] out_drive_duty;
  logic out_feedback_valid;
  logic [PCT_W-1:0] out_position_pct;
  logic out_span_fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  steering_position_servo dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the servo: configuration and internal state.
  // ---------------------------------------------------------------------------
  int unsigned sh_left, sh_right, sh_wdog, sh_tol_pct, sh_tol_floor, sh_duty_lo, sh_duty_hi;
  int unsigned win_mem[TAPS];
  int unsigned win_sum, win_slot, filt_val, target_pos, silence;
  bit win_full, target_ok, estop, offline;

  servo_req_t pending_reqs[$];
  servo_rsp_t expected_results[$];
  int fails = 0;
  int cyc = 0;
  bit in_taken = 1'b0;
  bit quiet;

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  function automatic void shadow_reset();
    sh_left = 1242; sh_right = 2865; sh_wdog = 500; sh_tol_pct = 4;
    sh_tol_floor = 25; sh_duty_lo = 135; sh_duty_hi = 195;
    foreach (win_mem[i]) win_mem[i] = 0;
    win_sum = 0; win_slot = 0; win_full = 0; filt_val = 0;
    target_pos = 0; target_ok = 0; estop = 0; offline = 1; silence = 0;
  endfunction

  // Moving average: divide by the fill count until the window is full.
  function automatic void push_sample(int unsigned v);
    win_sum = win_sum - win_mem[win_slot] + v;
    win_mem[win_slot] = v;
    win_slot++;
    if (win_slot >= TAPS) begin
      win_slot = 0;
      win_full = 1;
    end
    filt_val = win_full ? win_sum / TAPS : win_sum / win_slot;
  endfunction

  // Position feedback; zero span reports position 0 with the fault flag.
  function automatic void position_report(ref servo_rsp_t r);
    longint lo, hi, p;
    lo = (sh_left < sh_right) ? sh_left : sh_right;
    hi = (sh_left < sh_right) ? sh_right : sh_left;
    p = filt_val;
    r.fb_valid = 1;
    if (sh_left == sh_right) begin
      r.span_fault = 1;
      return;
    end
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    p = (p - longint'(sh_left)) * 100 / (longint'(sh_right) - longint'(sh_left));
    r.pct = p[PCT_W-1:0];
  endfunction

  // Predicts the result of one transaction; returns 1 when a result is due.
  function automatic bit servo_step(servo_req_t q, output servo_rsp_t r);
    longint err, mag, span, tol, duty, pc;
    r = '{default: '0};
    case (q.kind)
      REQ_SAMPLE: begin
        r.drv_valid = 1;
        if (offline || estop) return 1;
        push_sample(q.adc);
        if (!target_ok) return 1;
        err = longint'(target_pos) - longint'(filt_val);
        mag = (err < 0) ? -err : err;
        span = (sh_right >= sh_left) ? sh_right - sh_left : sh_left - sh_right;
        tol = span * sh_tol_pct / 100;
        if (tol < sh_tol_floor) tol = sh_tol_floor;
        if (mag <= tol) return 1;
        if (span == 0) duty = sh_duty_hi;
        else duty = mag * (longint'(sh_duty_hi) - longint'(sh_duty_lo)) / span
                    + longint'(sh_duty_lo);
        if (duty < 0) duty = 0;
        if (duty > 255) duty = 255;
        r.dir = (err > 0) ? DIR_FORWARD : DIR_REVERSE;
        r.duty = duty[7:0];
        return 1;
      end
      REQ_COMMAND: begin
        silence = 0; offline = 0;
        if (estop || !q.has) return 0;
        pc = (q.pay > 100) ? 100 : q.pay;
        pc = pc * (longint'(sh_right) - longint'(sh_left)) / 100 + longint'(sh_left);
        target_pos = pc[11:0];
        target_ok = 1;
        position_report(r);
        return 1;
      end
      REQ_EMERGENCY: begin
        silence = 0; offline = 0;
        if (!q.has) return 0;
        estop = (q.pay == 1);
        r.drv_valid = estop;
        position_report(r);
        return 1;
      end
      default: begin
        if (silence < 16'hFFFF) silence++;
        if (!offline && silence > sh_wdog) begin
          offline = 1;
          r.drv_valid = 1;
          return 1;
        end
        return 0;
      end
    endcase
  endfunction

  // Prediction at acceptance, plus shadow register updates.
  always @(posedge clk) begin
    servo_rsp_t r;
    servo_req_t q;
    cyc <= cyc + 1;
    if (!rst_n) begin
      shadow_reset();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAL_LEFT:   sh_left      = cfg_data[11:0];
          CFG_CAL_RIGHT:  sh_right     = cfg_data[11:0];
          CFG_WDOG_LIMIT: sh_wdog      = cfg_data;
          CFG_TOL_PCT:    sh_tol_pct   = cfg_data[6:0];
          CFG_TOL_FLOOR:  sh_tol_floor = cfg_data[11:0];
          CFG_DUTY_LOW:   sh_duty_lo   = cfg_data[7:0];
          CFG_DUTY_HIGH:  sh_duty_hi   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        q = '{in_req_type, in_adc_sample, in_payload_byte, in_has_payload};
        if (servo_step(q, r)) expected_results.push_back(r);
      end
    end
  end

  // Driver: a new transaction goes out only once the previous one was taken.
  always @(negedge clk) begin
    servo_req_t q;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
        q = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_req_type <= q.kind;
        in_adc_sample <= q.adc;
        in_payload_byte <= q.pay;
        in_has_payload <= q.has;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(negedge clk)
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 16);

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    servo_rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        fails++;
      end else begin
        e = expected_results.pop_front();
        if (out_drive_valid !== e.drv_valid) begin
          $error("drive_valid exp %0d got %0d", e.drv_valid, out_drive_valid); fails++;
        end
        if (out_drive_dir !== e.dir) begin
          $error("drive_dir exp %0d got %0d", e.dir, out_drive_dir); fails++;
        end
        if (out_drive_duty !== e.duty) begin
          $error("drive_duty exp %0d got %0d", e.duty, out_drive_duty); fails++;
        end
        if (out_feedback_valid !== e.fb_valid) begin
          $error("feedback_valid exp %0d got %0d", e.fb_valid, out_feedback_valid); fails++;
        end
        if (out_position_pct !== e.pct) begin
          $error("position_pct exp %0d got %0d", e.pct, out_position_pct); fails++;
        end
        if (out_span_fault !== e.span_fault) begin
          $error("span_fault exp %0d got %0d", e.span_fault, out_span_fault); fails++;
        end
      end
    end
  end

  // Watchdog on forward progress.
  int stuck = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("steering_position_servo verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_req(logic [1:0] k, int a, int p, bit h);
    pending_reqs.push_back('{k, a[11:0], p[7:0], h});
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Dropped frames give no result, so let the block settle before reconfiguring.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_all(int l, int r, int w, int tp, int tf, int dl, int dh);
    reg_write(CFG_CAL_LEFT, l);
    reg_write(CFG_CAL_RIGHT, r);
    reg_write(CFG_WDOG_LIMIT, w);
    reg_write(CFG_TOL_PCT, tp);
    reg_write(CFG_TOL_FLOOR, tf);
    reg_write(CFG_DUTY_LOW, dl);
    reg_write(CFG_DUTY_HIGH, dh);
  endtask

  // Mostly well-formed control traffic: commands, bursts of samples, ticks,
  // occasional emergency stop/clear pairs and malformed frames.
  task automatic random_traffic(int n);
    int k, sel, burst;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        add_req(REQ_COMMAND, $urandom, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                               : $urandom_range(100),
                $urandom_range(19) != 0);
        k++;
      end else if (sel < 17) begin
        add_req(REQ_EMERGENCY, $urandom, ($urandom_range(1) == 0) ? 1 : $urandom_range(255),
                $urandom_range(9) != 0);
        add_req(REQ_EMERGENCY, $urandom, $urandom_range(255), 1'b1);
        k += 2;
      end else if (sel < 35) begin
        burst = $urandom_range(1, 8);
        repeat (burst) add_req(REQ_TICK, $urandom, $urandom, $urandom_range(1));
        k += burst;
      end else begin
        burst = $urandom_range(1, 10);
        repeat (burst) add_req(REQ_SAMPLE, ($urandom_range(4) == 0) ? $urandom_range(4095)
                                           : $urandom_range(900, 3200),
                               $urandom, $urandom_range(1));
        k += burst;
      end
    end
  endtask

  initial begin
    int wd;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings.
    add_req(REQ_SAMPLE, 4095, 255, 1);   // offline: blocked step
    add_req(REQ_COMMAND, 0, 50, 0);      // no payload: wakes only
    add_req(REQ_SAMPLE, 0, 0, 0);        // no target yet
    add_req(REQ_COMMAND, 4095, 0, 1);
    add_req(REQ_SAMPLE, 4095, 0, 1);     // reverse
    add_req(REQ_COMMAND, 0, 255, 1);     // clamped to 100
    add_req(REQ_SAMPLE, 2000, 0, 0);     // forward
    add_req(REQ_EMERGENCY, 0, 1, 1);     // stop
    add_req(REQ_SAMPLE, 3000, 0, 0);     // blocked by emergency
    add_req(REQ_COMMAND, 0, 30, 1);      // dropped in emergency
    add_req(REQ_EMERGENCY, 0, 1, 0);     // no payload
    add_req(REQ_EMERGENCY, 0, 0, 1);     // clear
    add_req(REQ_SAMPLE, 1500, 0, 0);
    drain();

    // Zero span, no deadband, tiny watchdog.
    write_all(2000, 2000, 2, 0, 0, 0, 255);
    add_req(REQ_COMMAND, 0, 40, 1);
    add_req(REQ_SAMPLE, 1000, 0, 1);
    add_req(REQ_SAMPLE, 2000, 0, 1);
    repeat (4) add_req(REQ_TICK, 4095, 255, 1);  // goes offline on the third
    add_req(REQ_SAMPLE, 100, 0, 0);
    drain();

    // Inverted calibration, full deadband extremes, falling duty.
    write_all(4095, 0, 1, 100, 4095, 255, 0);
    add_req(REQ_COMMAND, 0, 100, 1);
    add_req(REQ_SAMPLE, 4095, 0, 0);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_TICK, 0, 0, 0);
    drain();

    // Watchdog disabled, widest span.
    write_all(0, 4095, 65535, 0, 0, 0, 255);
    add_req(REQ_COMMAND, 0, 100, 1);
    repeat (12) add_req(REQ_SAMPLE, 0, 0, 0);
    add_req(REQ_EMERGENCY, 0, 7, 1);
    random_traffic(190);
    drain();

    // Random phases with random register settings.
    repeat (6) begin
      case ($urandom_range(3))
        0: wd = 65535;
        1: wd = $urandom_range(1, 20);
        default: wd = $urandom_range(1, 400);
      endcase
      write_all($urandom_range(4095), $urandom_range(4095), wd, $urandom_range(100),
                ($urandom_range(1) == 0) ? $urandom_range(60) : $urandom_range(4095),
                $urandom_range(255), $urandom_range(255));
      random_traffic(190);
      drain();
    end

    // Back to the reset values for a final phase.
    write_all(1242, 2865, 500, 4, 25, 135, 195);
    random_traffic(150);
    drain();

    if (fails == 0)
      $display("steering_position_servo verification clean");
    else
      $display("steering_position_servo verification failed");
    $finish;
  end

endmodule
